[hw/rtl/tdu_pkg.sv]
package tdu_pkg;

  // field widths
  localparam int OPCODE_W = 3;
  localparam int SEC_W    = 63;
  localparam int MICRO_W  = 20;
  localparam int DIFF_W   = 64;

  // opcode layout: bit 0 set selects unsigned mode, bits 2:1 select the unit
  localparam int OP_UNSIGNED_BIT = 0;
  localparam int OP_UNIT_LSB     = 1;

  // scale factors
  localparam logic [19:0] USEC_PER_SEC  = 20'd1000000;
  localparam logic [9:0]  USEC_PER_MSEC = 10'd1000;

  // seconds gap bits that can reach the multipliers once the limit check passed
  localparam int USEC_GAP_W = 45;
  localparam int MSEC_GAP_W = 55;

  // floor division by 1000 through a reciprocal, exact for 20-bit inputs
  localparam int          MSEC_W        = 11;
  localparam int          DIV_PROD_W    = 42;
  localparam int          DIV1000_SHIFT = 31;
  localparam logic [21:0] DIV1000_MUL   = 22'd2147484;

  // micro term, signed, and the lowest value that still fits after a borrow
  localparam int                 TERM_W        = 21;
  localparam logic signed [20:0] TERM_MIN_USEC = -21'sd1000000;
  localparam logic signed [20:0] TERM_MIN_MSEC = -21'sd1000;

  typedef enum logic [1:0] {
    UNIT_USEC = 2'd0,
    UNIT_MSEC = 2'd1,
    UNIT_SEC  = 2'd2
  } unit_e;

  typedef enum logic [2:0] {
    RES_CALC = 3'd0,
    RES_ZERO = 3'd1,
    RES_UMAX = 3'd2,
    RES_SMAX = 3'd3,
    RES_SMIN = 3'd4
  } res_sel_e;

  typedef struct packed {
    logic [OPCODE_W-1:0] opcode;
    logic [SEC_W-1:0]    first_seconds;
    logic [MICRO_W-1:0]  first_micros;
    logic [SEC_W-1:0]    second_seconds;
    logic [MICRO_W-1:0]  second_micros;
  } in_t;

  typedef struct packed {
    res_sel_e           sel;
    logic               neg;
    logic               sgn;
    unit_e              unit;
    logic [SEC_W-1:0]   gap;
    logic [MICRO_W-1:0] x1;
    logic [MICRO_W-1:0] x2;
  } s1_t;

  typedef struct packed {
    res_sel_e                  sel;
    logic                      neg;
    logic                      sgn;
    logic [DIFF_W-1:0]         prod;
    logic signed [TERM_W-1:0]  term;
    logic                      under;
  } s2_t;

  typedef struct packed {
    res_sel_e          sel;
    logic              neg;
    logic [DIFF_W-1:0] mag;
  } s3_t;

  function automatic logic [MSEC_W-1:0] div_1000(input logic [MICRO_W-1:0] x);
    logic [DIV_PROD_W-1:0] p;
    p = DIV_PROD_W'(x) * DIV_PROD_W'(DIV1000_MUL);
    return p[DIV1000_SHIFT +: MSEC_W];
  endfunction

endpackage

[hw/rtl/timestamp_difference_unit_core.sv]
// channel  | direction | handshake                | payload
// ---------+-----------+--------------------------+-------------------------------------------
// input    | in        | in_valid_i / in_stall_o  | opcode, first/second seconds and micros
// output   | out       | out_valid_o / out_stall_i| difference
//
// One transaction per cycle sustained while out_stall_i stays low; a result passes
// through the five register levels (input, compare, scale, clamp, output) in order.
// Reset clears only the valid bits of the five levels.
// An output stall holds the output register; empty levels keep filling, and
// in_stall_o rises only once every level holds a transaction.
module timestamp_difference_unit_core #(
  parameter int RESULT_BITS = 64
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [tdu_pkg::OPCODE_W-1:0] opcode_i,
  input  logic [tdu_pkg::SEC_W-1:0]   first_seconds_i,
  input  logic [tdu_pkg::MICRO_W-1:0] first_micros_i,
  input  logic [tdu_pkg::SEC_W-1:0]   second_seconds_i,
  input  logic [tdu_pkg::MICRO_W-1:0] second_micros_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [tdu_pkg::DIFF_W-1:0]  difference_o
);
  import tdu_pkg::*;

  localparam int NUM_STAGES = 5;

  logic [NUM_STAGES-1:0] v_d, v_q;
  logic [NUM_STAGES-1:0] rdy;
  in_t                   in_q;
  s1_t                   s1;
  s2_t                   s2;

  // a level can load when it is empty or the next one loads
  always_comb begin
    rdy[NUM_STAGES-1] = ~v_q[NUM_STAGES-1] | ~out_stall_i;
    for (int k = NUM_STAGES - 2; k >= 0; k--) begin
      rdy[k] = ~v_q[k] | rdy[k+1];
    end
  end

  // valid bits move along with their transaction
  always_comb begin
    v_d[0] = rdy[0] ? in_valid_i : v_q[0];
    for (int k = 1; k < NUM_STAGES; k++) begin
      v_d[k] = rdy[k] ? v_q[k-1] : v_q[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= v_d;
    end
  end

  // input register
  always_ff @(posedge clk_i) begin
    if (rdy[0]) begin
      in_q.opcode         <= opcode_i;
      in_q.first_seconds  <= first_seconds_i;
      in_q.first_micros   <= first_micros_i;
      in_q.second_seconds <= second_seconds_i;
      in_q.second_micros  <= second_micros_i;
    end
  end

  tdu_compare #(
    .RESULT_BITS(RESULT_BITS)
  ) u_compare (
    .clk_i(clk_i),
    .en_i (rdy[1]),
    .in_i (in_q),
    .s1_o (s1)
  );

  tdu_scale u_scale (
    .clk_i(clk_i),
    .en_i (rdy[2]),
    .s1_i (s1),
    .s2_o (s2)
  );

  tdu_finish #(
    .RESULT_BITS(RESULT_BITS)
  ) u_finish (
    .clk_i       (clk_i),
    .clamp_en_i  (rdy[3]),
    .out_en_i    (rdy[4]),
    .s2_i        (s2),
    .difference_o(difference_o)
  );

  assign in_stall_o  = ~rdy[0];
  assign out_valid_o = v_q[NUM_STAGES-1];

endmodule

[hw/rtl/tdu_compare.sv]
module tdu_compare #(
  parameter int RESULT_BITS = 64
) (
  input  logic         clk_i,
  input  logic         en_i,
  input  tdu_pkg::in_t in_i,
  output tdu_pkg::s1_t s1_o
);
  import tdu_pkg::*;

  localparam logic [DIFF_W-1:0] U_MAX = DIFF_W'((65'd1 << RESULT_BITS) - 65'd1);
  localparam logic [DIFF_W-1:0] S_MAX = U_MAX >> 1;
  localparam logic [DIFF_W-1:0] LIM_US_S = S_MAX / DIFF_W'(USEC_PER_SEC) - 64'd1;
  localparam logic [DIFF_W-1:0] LIM_US_U = U_MAX / DIFF_W'(USEC_PER_SEC) - 64'd1;
  localparam logic [DIFF_W-1:0] LIM_MS_S = S_MAX / DIFF_W'(USEC_PER_MSEC) - 64'd1;
  localparam logic [DIFF_W-1:0] LIM_MS_U = U_MAX / DIFF_W'(USEC_PER_MSEC) - 64'd1;
  localparam logic [DIFF_W-1:0] LIM_SEC_S = S_MAX - 64'd1;
  localparam logic [DIFF_W-1:0] LIM_SEC_U = U_MAX;

  s1_t               s1_d, s1_q;
  logic              sgn;
  unit_e             unit;
  logic              sec_eq, a_gt_b, au_ge;
  logic [SEC_W-1:0]  gap;
  logic [MICRO_W-1:0] dmu;
  logic [DIFF_W-1:0] lim;
  logic              over;

  // seconds compare and gap, micro distance
  assign sgn    = ~in_i.opcode[OP_UNSIGNED_BIT];
  assign unit   = unit_e'(in_i.opcode[OP_UNIT_LSB +: 2]);
  assign sec_eq = in_i.first_seconds == in_i.second_seconds;
  assign a_gt_b = in_i.first_seconds > in_i.second_seconds;
  assign gap    = a_gt_b ? in_i.first_seconds - in_i.second_seconds
                         : in_i.second_seconds - in_i.first_seconds;
  assign au_ge  = in_i.first_micros >= in_i.second_micros;
  assign dmu    = au_ge ? in_i.first_micros - in_i.second_micros
                        : in_i.second_micros - in_i.first_micros;

  // saturation limit on the seconds gap
  always_comb begin
    unique case (unit)
      UNIT_USEC: lim = sgn ? LIM_US_S : LIM_US_U;
      UNIT_MSEC: lim = sgn ? LIM_MS_S : LIM_MS_U;
      UNIT_SEC:  lim = sgn ? LIM_SEC_S : LIM_SEC_U;
      default:   lim = '0;
    endcase
  end

  assign over = {1'b0, gap} > lim;

  // classify the transaction and pick the operands for the scale stage
  always_comb begin
    s1_d.sel  = RES_CALC;
    s1_d.neg  = 1'b0;
    s1_d.sgn  = sgn;
    s1_d.unit = unit;
    s1_d.gap  = gap;
    s1_d.x1   = a_gt_b ? in_i.first_micros : in_i.second_micros;
    s1_d.x2   = a_gt_b ? in_i.second_micros : in_i.first_micros;
    priority if (unit != UNIT_USEC && unit != UNIT_MSEC && unit != UNIT_SEC) begin
      s1_d.sel = RES_ZERO;
    end else if (sec_eq) begin
      // same second: only the micro distance counts
      s1_d.gap = '0;
      s1_d.x1  = dmu;
      s1_d.x2  = '0;
      if (unit == UNIT_SEC) begin
        s1_d.sel = RES_ZERO;
      end else if (!au_ge) begin
        if (!sgn) s1_d.sel = RES_ZERO;
        else      s1_d.neg = 1'b1;
      end
    end else if (!sgn && !a_gt_b) begin
      s1_d.sel = RES_ZERO;
    end else if (over) begin
      if (!sgn)        s1_d.sel = RES_UMAX;
      else if (a_gt_b) s1_d.sel = RES_SMAX;
      else             s1_d.sel = RES_SMIN;
    end else begin
      s1_d.neg = sgn & ~a_gt_b;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) s1_q <= s1_d;
  end

  assign s1_o = s1_q;

endmodule

[hw/rtl/tdu_scale.sv]
module tdu_scale (
  input  logic         clk_i,
  input  logic         en_i,
  input  tdu_pkg::s1_t s1_i,
  output tdu_pkg::s2_t s2_o
);
  import tdu_pkg::*;

  s2_t                s2_d, s2_q;
  logic [DIFF_W:0]    prod_us, prod_ms;
  logic [MSEC_W-1:0]  d1, d2;

  // gap times the unit scale, only the low gap bits can survive the limit check
  assign prod_us = (DIFF_W+1)'(s1_i.gap[USEC_GAP_W-1:0]) * (DIFF_W+1)'(USEC_PER_SEC);
  assign prod_ms = (DIFF_W+1)'(s1_i.gap[MSEC_GAP_W-1:0]) * (DIFF_W+1)'(USEC_PER_MSEC);

  // each micro part floored to milliseconds
  assign d1 = div_1000(s1_i.x1);
  assign d2 = div_1000(s1_i.x2);

  // a borrowed second is folded into a negative micro term
  always_comb begin
    s2_d.sel = s1_i.sel;
    s2_d.neg = s1_i.neg;
    s2_d.sgn = s1_i.sgn;
    unique case (s1_i.unit)
      UNIT_USEC: begin
        s2_d.prod  = prod_us[DIFF_W-1:0];
        s2_d.term  = signed'(TERM_W'(s1_i.x1)) - signed'(TERM_W'(s1_i.x2));
        s2_d.under = s2_d.term < TERM_MIN_USEC;
      end
      UNIT_MSEC: begin
        s2_d.prod  = prod_ms[DIFF_W-1:0];
        s2_d.term  = signed'(TERM_W'(d1)) - signed'(TERM_W'(d2));
        s2_d.under = s2_d.term < TERM_MIN_MSEC;
      end
      default: begin
        s2_d.prod  = DIFF_W'(s1_i.gap);
        s2_d.term  = '0;
        s2_d.under = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en_i) s2_q <= s2_d;
  end

  assign s2_o = s2_q;

endmodule

[hw/rtl/tdu_finish.sv]
module tdu_finish #(
  parameter int RESULT_BITS = 64
) (
  input  logic                       clk_i,
  input  logic                       clamp_en_i,
  input  logic                       out_en_i,
  input  tdu_pkg::s2_t               s2_i,
  output logic [tdu_pkg::DIFF_W-1:0] difference_o
);
  import tdu_pkg::*;

  localparam logic [DIFF_W-1:0] U_MAX = DIFF_W'((65'd1 << RESULT_BITS) - 65'd1);
  localparam logic [DIFF_W-1:0] S_MAX = U_MAX >> 1;

  s3_t               s3_d, s3_q;
  logic [DIFF_W:0]   sum;
  logic [DIFF_W-1:0] cap;
  logic [DIFF_W-1:0] diff_d, diff_q;

  // add the micro term and clamp to the mode maximum
  assign sum = {1'b0, s2_i.prod} + (DIFF_W+1)'(s2_i.term);
  assign cap = s2_i.sgn ? S_MAX : U_MAX;

  always_comb begin
    s3_d.sel = s2_i.sel;
    s3_d.neg = s2_i.neg;
    priority if (sum[DIFF_W]) begin
      // a total below zero wraps around the 64-bit range before the clamp
      s3_d.mag = (sum[DIFF_W-1:0] > cap) ? cap : sum[DIFF_W-1:0];
    end else if (s2_i.under || sum > {1'b0, cap}) begin
      s3_d.mag = cap;
    end else begin
      s3_d.mag = sum[DIFF_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (clamp_en_i) s3_q <= s3_d;
  end

  // sign and saturation patterns
  always_comb begin
    unique case (s3_q.sel)
      RES_CALC: diff_d = (s3_q.neg ? (DIFF_W'(0) - s3_q.mag) : s3_q.mag) & U_MAX;
      RES_ZERO: diff_d = '0;
      RES_UMAX: diff_d = U_MAX;
      RES_SMAX: diff_d = S_MAX;
      RES_SMIN: diff_d = S_MAX + DIFF_W'(1);
      default:  diff_d = '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (out_en_i) diff_q <= diff_d;
  end

  assign difference_o = diff_q;

endmodule

[tb/timestamp_difference_checker.sv]
`timescale 1ns / 100ps

module timestamp_difference_checker
  import tdu_pkg::*;
#(
  parameter int RESULT_BITS = 64
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_stall_i,
  input  logic [OPCODE_W-1:0] opcode_i,
  input  logic [SEC_W-1:0]    first_seconds_i,
  input  logic [MICRO_W-1:0]  first_micros_i,
  input  logic [SEC_W-1:0]    second_seconds_i,
  input  logic [MICRO_W-1:0]  second_micros_i,
  input  logic                out_valid_i,
  input  logic                out_stall_i,
  input  logic [DIFF_W-1:0]   difference_i,
  output int                  mismatch_count_o,
  output int                  pending_count_o
);

  localparam logic [63:0] MICROS_PER_SECOND = 64'd1000000;
  localparam logic [63:0] MICROS_PER_MILLI  = 64'd1000;
  localparam logic [63:0] RESULT_MASK       = {64{1'b1}} >> (64 - RESULT_BITS);
  localparam int          REPORT_LIMIT      = 10;

  // differences still owed by the block, oldest first
  logic [DIFF_W-1:0] pending_differences[$];

  // first minus second in the unit picked by the opcode, with saturation
  function automatic logic [63:0] timestamp_difference(
    logic [OPCODE_W-1:0] op,
    logic [SEC_W-1:0]    a_sec,
    logic [MICRO_W-1:0]  a_us,
    logic [SEC_W-1:0]    b_sec,
    logic [MICRO_W-1:0]  b_us
  );
    logic        is_signed;
    logic        ahead;
    logic [1:0]  unit_code;
    logic [63:0] smax;
    logic [63:0] ceiling;
    logic [63:0] gap;
    logic [63:0] gap_limit;
    logic [63:0] late_us;
    logic [63:0] early_us;
    logic [63:0] scale;
    logic [63:0] mag;
    logic [63:0] total;
    is_signed = !op[OP_UNSIGNED_BIT];
    unit_code = op[OP_UNIT_LSB +: 2];
    smax      = RESULT_MASK >> 1;
    ceiling   = is_signed ? smax : RESULT_MASK;

    if (unit_code > UNIT_SEC) return '0;

    // same second: plain micro difference, msec truncates toward zero
    if (a_sec == b_sec) begin
      if (unit_code == UNIT_SEC) return '0;
      if (a_us >= b_us) begin
        mag = 64'(a_us) - 64'(b_us);
        return (unit_code == UNIT_MSEC) ? mag / MICROS_PER_MILLI : mag;
      end
      if (!is_signed) return '0;
      mag = 64'(b_us) - 64'(a_us);
      if (unit_code == UNIT_MSEC) mag = mag / MICROS_PER_MILLI;
      return (64'd0 - mag) & RESULT_MASK;
    end

    ahead = a_sec > b_sec;
    if (!is_signed && !ahead) return '0;
    if (ahead) begin
      gap      = 64'(a_sec) - 64'(b_sec);
      late_us  = 64'(a_us);
      early_us = 64'(b_us);
    end else begin
      gap      = 64'(b_sec) - 64'(a_sec);
      late_us  = 64'(b_us);
      early_us = 64'(a_us);
    end

    // seconds gap past the unit's range saturates
    case (unit_code)
      UNIT_USEC: gap_limit = ceiling / MICROS_PER_SECOND - 64'd1;
      UNIT_MSEC: gap_limit = ceiling / MICROS_PER_MILLI - 64'd1;
      default:   gap_limit = is_signed ? smax - 64'd1 : RESULT_MASK;
    endcase
    if (gap > gap_limit) begin
      if (!is_signed) return RESULT_MASK;
      return ahead ? smax : smax + 64'd1;
    end

    if (unit_code == UNIT_SEC) begin
      mag = gap;
    end else begin
      // borrow one second, then floor each micro part in msec mode
      if (late_us < early_us) begin
        late_us = late_us + MICROS_PER_SECOND;
        gap     = gap - 64'd1;
      end
      scale = MICROS_PER_SECOND;
      if (unit_code == UNIT_MSEC) begin
        late_us  = late_us / MICROS_PER_MILLI;
        early_us = early_us / MICROS_PER_MILLI;
        scale    = MICROS_PER_MILLI;
      end
      mag   = gap * scale;
      total = mag + (late_us - early_us);
      if (total < mag || total > ceiling) total = ceiling;
      mag = total;
    end

    if (is_signed && !ahead) return (64'd0 - mag) & RESULT_MASK;
    return mag & RESULT_MASK;
  endfunction

  initial begin
    mismatch_count_o = 0;
    pending_count_o  = 0;
  end

  // compare finished transactions, then log newly taken ones
  always @(posedge clk_i) begin
    logic [DIFF_W-1:0] wanted;
    if (rst_ni) begin
      if (out_valid_i && !out_stall_i) begin
        if (pending_differences.size() == 0) begin
          if (mismatch_count_o < REPORT_LIMIT)
            $display("%0t: result transaction with none pending, actual %h",
                     $realtime, difference_i);
          mismatch_count_o++;
        end else begin
          wanted = pending_differences.pop_front();
          if (difference_i !== wanted) begin
            if (mismatch_count_o < REPORT_LIMIT)
              $display("%0t: difference expected %h actual %h",
                       $realtime, wanted, difference_i);
            mismatch_count_o++;
          end
        end
      end
      if (in_valid_i && !in_stall_i)
        pending_differences.push_back(
          timestamp_difference(opcode_i, first_seconds_i, first_micros_i,
                               second_seconds_i, second_micros_i) & RESULT_MASK);
      pending_count_o = pending_differences.size();
    end
  end

endmodule

[tb/tb_timestamp_difference_unit_core.sv]
`timescale 1ns / 100ps

module tb_timestamp_difference_unit_core;
  import tdu_pkg::*;

  localparam int          RESULT_BITS   = 64;
  localparam int          RANDOM_ITEMS  = 1750;
  localparam int          FILL_ITEMS    = 60;
  localparam int          LONG_HOLD     = 200;
  localparam int          DRAIN_CYCLES  = 16;
  localparam int          CYCLE_LIMIT   = 300000;
  localparam logic        SIGNED_MODE   = 1'b0;
  localparam logic        UNSIGNED_MODE = 1'b1;
  localparam logic [1:0]  UNIT_NONE     = 2'd3;
  localparam logic [2:0]  OP_LAST       = {UNIT_SEC, UNSIGNED_MODE};
  localparam logic [62:0] SEC_MAX       = {SEC_W{1'b1}};
  localparam logic [19:0] MICRO_TOP     = 20'd999999;
  localparam logic [19:0] MICRO_FIELD   = {MICRO_W{1'b1}};
  localparam logic [63:0] WIDE_MAX      = {64{1'b1}} >> (64 - RESULT_BITS);
  localparam logic [63:0] WIDE_SMAX     = WIDE_MAX >> 1;

  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_LIGHT,
    STALL_ALTERNATE,
    STALL_HEAVY
  } stall_mode_e;

  logic                clk_i            = 1'b0;
  logic                rst_ni           = 1'b0;
  logic                in_valid         = 1'b0;
  logic                in_stall;
  logic [OPCODE_W-1:0] opcode           = '0;
  logic [SEC_W-1:0]    first_seconds    = '0;
  logic [MICRO_W-1:0]  first_micros     = '0;
  logic [SEC_W-1:0]    second_seconds   = '0;
  logic [MICRO_W-1:0]  second_micros    = '0;
  logic                out_valid;
  logic                out_stall        = 1'b0;
  logic [DIFF_W-1:0]   difference;
  int                  mismatch_count;
  int                  pending_count;

  int                  cycle_count      = 0;
  logic                hold_request     = 1'b0;
  int                  hold_cycles      = 0;
  stall_mode_e         stall_mode       = STALL_NONE;
  int                  mode_left        = 0;
  logic [63:0]         gap_limits[6];

  always #5 clk_i = ~clk_i;

  timestamp_difference_unit_core #(
    .RESULT_BITS(RESULT_BITS)
  ) dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid),
    .in_stall_o      (in_stall),
    .opcode_i        (opcode),
    .first_seconds_i (first_seconds),
    .first_micros_i  (first_micros),
    .second_seconds_i(second_seconds),
    .second_micros_i (second_micros),
    .out_valid_o     (out_valid),
    .out_stall_i     (out_stall),
    .difference_o    (difference)
  );

  timestamp_difference_checker #(
    .RESULT_BITS(RESULT_BITS)
  ) checker_inst (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid),
    .in_stall_i      (in_stall),
    .opcode_i        (opcode),
    .first_seconds_i (first_seconds),
    .first_micros_i  (first_micros),
    .second_seconds_i(second_seconds),
    .second_micros_i (second_micros),
    .out_valid_i     (out_valid),
    .out_stall_i     (out_stall),
    .difference_i    (difference),
    .mismatch_count_o(mismatch_count),
    .pending_count_o (pending_count)
  );

  // run limit
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // result side: one long hold-off on request, otherwise shifting stall patterns
  always @(negedge clk_i) begin
    if (hold_request && hold_cycles < LONG_HOLD) begin
      hold_cycles <= hold_cycles + 1;
      out_stall   <= 1'b1;
    end else begin
      if (mode_left == 0) begin
        stall_mode <= stall_mode_e'($urandom_range(0, 3));
        mode_left  <= $urandom_range(8, 80);
      end else begin
        mode_left <= mode_left - 1;
      end
      case (stall_mode)
        STALL_NONE:      out_stall <= 1'b0;
        STALL_LIGHT:     out_stall <= ($urandom_range(0, 3) == 0);
        STALL_ALTERNATE: out_stall <= ~out_stall;
        default:         out_stall <= ($urandom_range(0, 4) != 0);
      endcase
    end
  end

  // offer one transaction and hold it until taken
  task automatic offer_timestamps(logic [2:0] op, logic [62:0] a_sec, logic [19:0] a_us,
                                  logic [62:0] b_sec, logic [19:0] b_us);
    @(negedge clk_i);
    in_valid       <= 1'b1;
    opcode         <= op;
    first_seconds  <= a_sec;
    first_micros   <= a_us;
    second_seconds <= b_sec;
    second_micros  <= b_us;
    do @(posedge clk_i); while (in_stall);
  endtask

  // mostly legal micros, with the edges and out-of-range values mixed in
  function automatic logic [19:0] random_micros();
    case ($urandom_range(0, 19))
      0:       return '0;
      1:       return MICRO_TOP;
      2:       return 20'($urandom_range(MICRO_TOP + 1, MICRO_FIELD));
      default: return 20'($urandom_range(0, MICRO_TOP));
    endcase
  endfunction

  initial begin
    logic [2:0]  op;
    logic [63:0] gap;
    logic [63:0] base;
    logic [63:0] span;
    logic [62:0] lo_sec;
    logic [62:0] hi_sec;
    int          burst_left;
    int          idle_len;

    gap_limits[0] = WIDE_SMAX / 64'd1000000 - 64'd1;
    gap_limits[1] = WIDE_MAX / 64'd1000000 - 64'd1;
    gap_limits[2] = WIDE_SMAX / 64'd1000 - 64'd1;
    gap_limits[3] = WIDE_MAX / 64'd1000 - 64'd1;
    gap_limits[4] = WIDE_SMAX - 64'd1;
    gap_limits[5] = 64'(SEC_MAX);

    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: every opcode with a borrow and with equal seconds
    for (int i = 0; i < 8; i++) begin
      offer_timestamps(3'(i), 63'd1000, 20'd250, 63'd998, 20'd999500);
      offer_timestamps(3'(i), 63'd77, 20'd1500, 63'd77, 20'd400999);
    end
    // seconds at the field extremes, signed sec saturation both ways
    offer_timestamps({UNIT_SEC, SIGNED_MODE}, SEC_MAX, '0, '0, '0);
    offer_timestamps({UNIT_SEC, UNSIGNED_MODE}, SEC_MAX, MICRO_FIELD, '0, '0);
    offer_timestamps({UNIT_SEC, SIGNED_MODE}, '0, '0, SEC_MAX, MICRO_FIELD);
    // usec gap right at the limit and one past it
    offer_timestamps({UNIT_USEC, SIGNED_MODE}, 63'(gap_limits[0]), MICRO_TOP, '0, '0);
    offer_timestamps({UNIT_USEC, SIGNED_MODE}, '0, '0, 63'(gap_limits[0] + 64'd1), '0);
    // micros past a second, borrow that still leaves the late part short
    offer_timestamps({UNIT_USEC, UNSIGNED_MODE}, 63'd6, '0, 63'd5, MICRO_FIELD);
    // unsigned with the first timestamp earlier
    offer_timestamps({UNIT_MSEC, UNSIGNED_MODE}, 63'd3, MICRO_TOP, 63'd9, '0);

    // random: the first stretch runs back to back against a long output hold
    hold_request = 1'b1;
    burst_left   = FILL_ITEMS;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (burst_left == 0) begin
        idle_len = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        if (idle_len > 0) begin
          @(negedge clk_i);
          in_valid <= 1'b0;
          repeat (idle_len - 1) @(negedge clk_i);
        end
        burst_left = $urandom_range(1, 30);
      end
      burst_left--;

      if ($urandom_range(0, 31) == 0)
        op = {UNIT_NONE, 1'($urandom_range(0, 1))};
      else
        op = 3'($urandom_range(0, OP_LAST));

      // seconds gap: equal, tiny, around the saturation point, up to 2^20, wide
      case ($urandom_range(0, 9))
        0, 1:    gap = '0;
        2, 3:    gap = 64'($urandom_range(1, 3));
        4, 5, 6: begin
          gap = gap_limits[(op > OP_LAST) ? 3'(op[0]) : op] + 64'($urandom_range(0, 6)) - 64'd3;
          if (gap > 64'(SEC_MAX)) gap = 64'(SEC_MAX);
        end
        7:       gap = 64'($urandom_range(0, 1 << 20));
        default: gap = {1'b0, 32'($urandom) >> $urandom_range(0, 31), 31'($urandom)};
      endcase

      span = 64'(SEC_MAX) - gap;
      case ($urandom_range(0, 15))
        0:       base = '0;
        1:       base = span;
        default: base = {1'b0, 32'($urandom), 31'($urandom)} % (span + 64'd1);
      endcase
      lo_sec = 63'(base);
      hi_sec = 63'(base + gap);

      if ($urandom_range(0, 1) == 0)
        offer_timestamps(op, hi_sec, random_micros(), lo_sec, random_micros());
      else
        offer_timestamps(op, lo_sec, random_micros(), hi_sec, random_micros());
    end

    @(negedge clk_i);
    in_valid <= 1'b0;

    // drain, then give any stray result time to show up
    while (pending_count != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);

    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

[filelist.f]
hw/rtl/tdu_pkg.sv
hw/rtl/tdu_compare.sv
hw/rtl/tdu_scale.sv
hw/rtl/tdu_finish.sv
hw/rtl/timestamp_difference_unit_core.sv
tb/timestamp_difference_checker.sv
tb/tb_timestamp_difference_unit_core.sv
